### hw/rtl/skas_pkg.sv
// Package for the sorted key-sum aggregator: table size, opcodes, FSM states
// and the control struct broadcast to the cell chain. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package skas_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } skas_state_t;

  // Command broadcast to every cell at once.
  typedef struct packed {
    logic        acc_en;    // add value into the matching entry
    logic        ins_en;    // insert new key at its sorted slot
    logic        shift_en;  // move every entry one cell toward the head
    logic [31:0] key;
    logic [31:0] value;
  } skas_cmd_t;

endpackage
`default_nettype wire

### hw/rtl/skas_if.sv
// Valid/ready channel interfaces for the aggregator's request and result sides.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface skas_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] rec_key;
  logic [31:0] rec_value;

  modport source (output valid, output op, output rec_key, output rec_value, input ready);
  modport sink   (input valid, input op, input rec_key, input rec_value, output ready);
endinterface

interface skas_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_key;
  logic [31:0] out_sum;
  logic        entry_valid;
  logic        overflowed;
  logic        last;

  modport source (output valid, output out_key, output out_sum, output entry_valid,
                  output overflowed, output last, input ready);
  modport sink   (input valid, input out_key, input out_sum, input entry_valid,
                  input overflowed, input last, output ready);
endinterface
`default_nettype wire

### hw/rtl/skas_cell.sv
// One table cell: holds a key and its running sum, compares against the
// broadcast key and trades contents with its neighbors. Uses skas_pkg.
`timescale 1ns / 1ps
`default_nettype none
module skas_cell (
  input  wire logic               clk,
  input  wire skas_pkg::skas_cmd_t cmd,
  input  wire logic               valid,     // cell lies inside the filled region
  input  wire logic               prev_lt,   // left neighbor holds a smaller key
  input  wire logic [31:0]        prev_key,
  input  wire logic [31:0]        prev_sum,
  input  wire logic [31:0]        next_key,
  input  wire logic [31:0]        next_sum,
  output logic                    lt,
  output logic                    eq,
  output logic [31:0]             key,
  output logic [31:0]             sum
);

  logic [31:0] key_r, key_nxt;
  logic [31:0] sum_r, sum_nxt;

  assign lt  = valid && ($signed(key_r) < $signed(cmd.key));
  assign eq  = valid && (key_r == cmd.key);
  assign key = key_r;
  assign sum = sum_r;

  always_comb begin
    key_nxt = key_r;
    sum_nxt = sum_r;
    priority if (cmd.shift_en) begin
      key_nxt = next_key;
      sum_nxt = next_sum;
    end else if (cmd.acc_en) begin
      if (eq) begin
        sum_nxt = sum_r + cmd.value;
      end
    end else if (cmd.ins_en) begin
      // keep smaller keys, take the new key at the boundary, shift the rest right
      if (!lt) begin
        if (prev_lt) begin
          key_nxt = cmd.key;
          sum_nxt = cmd.value;
        end else begin
          key_nxt = prev_key;
          sum_nxt = prev_sum;
        end
      end
    end else begin
      // no command: hold
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    sum_r <= sum_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/sorted_key_sum_aggregator.sv
// Top level of the sorted key-sum aggregator: cell chain, fill count and the
// flush sequencer with its output register. Uses skas_pkg, skas_if, skas_cell.
//
// For an add request, every cell compares its key with the
// request's key at once, so the matching cell accumulates or the chain opens
// a slot and inserts, and the next request is taken in the following cycle.
// A flush request drains the chain one entry per cycle, while the output
// register is not stalled, through the head cell into the output register;
// requests are held off until the last result is loaded. An empty table flushes
// as a single result with entry_valid low and last high.
// Table capacity is skas_pkg::TABLE_ENTRIES; new keys beyond it are dropped
// and flagged in overflowed until the next flush completes.
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_sum_aggregator (
  input  wire logic clk,
  input  wire logic rst_n,
  skas_in_if.sink   in_ch,
  skas_out_if.source out_ch
);

  localparam int N = skas_pkg::TABLE_ENTRIES;
  localparam int W = skas_pkg::CNT_W;

  skas_pkg::skas_state_t state_r, state_nxt;
  logic [W-1:0]          count_r, count_nxt;
  logic                  ovf_r, ovf_nxt;
  skas_pkg::skas_cmd_t   cmd;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_key_r, out_key_nxt;
  logic [31:0] out_sum_r, out_sum_nxt;
  logic        out_ev_r, out_ev_nxt;
  logic        out_ovf_r, out_ovf_nxt;
  logic        out_last_r, out_last_nxt;

  logic [31:0] cell_key [N];
  logic [31:0] cell_sum [N];
  logic [N-1:0] cell_lt;
  logic [N-1:0] cell_eq;

  logic accept;
  logic hit;
  logic full;
  logic load;
  logic done;

  assign in_ch.ready = (state_r == skas_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign hit         = |cell_eq;
  assign full        = (count_r == W'(N));
  assign load        = !out_valid_r || out_ch.ready;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic        valid_c;
    logic        prev_lt_c;
    logic [31:0] prev_key_c, prev_sum_c, next_key_c, next_sum_c;

    assign valid_c = (count_r > W'(i));
    if (i == 0) begin : g_head
      assign prev_lt_c  = 1'b1;
      assign prev_key_c = '0;
      assign prev_sum_c = '0;
    end else begin : g_body
      assign prev_lt_c  = cell_lt[i-1];
      assign prev_key_c = cell_key[i-1];
      assign prev_sum_c = cell_sum[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign next_key_c = '0;
      assign next_sum_c = '0;
    end else begin : g_link
      assign next_key_c = cell_key[i+1];
      assign next_sum_c = cell_sum[i+1];
    end

    skas_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .valid    (valid_c),
      .prev_lt  (prev_lt_c),
      .prev_key (prev_key_c),
      .prev_sum (prev_sum_c),
      .next_key (next_key_c),
      .next_sum (next_sum_c),
      .lt       (cell_lt[i]),
      .eq       (cell_eq[i]),
      .key      (cell_key[i]),
      .sum      (cell_sum[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    cmd.acc_en    = 1'b0;
    cmd.ins_en    = 1'b0;
    cmd.shift_en  = 1'b0;
    cmd.key       = in_ch.rec_key;
    cmd.value     = in_ch.rec_value;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_key_nxt   = out_key_r;
    out_sum_nxt   = out_sum_r;
    out_ev_nxt    = out_ev_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    done          = 1'b0;

    unique case (state_r)
      skas_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_ch.op == skas_pkg::OP_ADD) begin
            priority if (hit) begin
              cmd.acc_en = 1'b1;
            end else if (full) begin
              ovf_nxt = 1'b1;   // drop the new key
            end else begin
              cmd.ins_en = 1'b1;
              count_nxt  = count_r + W'(1);
            end
          end else begin
            state_nxt = skas_pkg::ST_DRAIN;
          end
        end
      end
      skas_pkg::ST_DRAIN: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_ovf_nxt   = ovf_r;
          if (count_r == '0) begin
            out_key_nxt  = '0;
            out_sum_nxt  = '0;
            out_ev_nxt   = 1'b0;
            out_last_nxt = 1'b1;
            done         = 1'b1;
          end else begin
            // emit the head entry and advance the chain
            out_key_nxt  = cell_key[0];
            out_sum_nxt  = cell_sum[0];
            out_ev_nxt   = 1'b1;
            out_last_nxt = (count_r == W'(1));
            cmd.shift_en = 1'b1;
            count_nxt    = count_r - W'(1);
            done         = (count_r == W'(1));
          end
          if (done) begin
            state_nxt = skas_pkg::ST_IDLE;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = skas_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skas_pkg::ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_key_r  <= out_key_nxt;
    out_sum_r  <= out_sum_nxt;
    out_ev_r   <= out_ev_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_key     = out_key_r;
  assign out_ch.out_sum     = out_sum_r;
  assign out_ch.entry_valid = out_ev_r;
  assign out_ch.overflowed  = out_ovf_r;
  assign out_ch.last        = out_last_r;

endmodule
`default_nettype wire

### hw/rtl/skas_checker.sv
// Port-level checks for the sorted key-sum aggregator, bound to the top level.
// Depends on sorted_key_sum_aggregator and the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
module skas_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_op,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_entry_valid,
  input wire logic out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_last)
      && $stable(out_entry_valid))
    else $error("stalled result changed");

  // an empty-table result is always the only one of its flush
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |-> out_last)
    else $error("empty result without last");

  // while a flush still has entries to send, requests are held off
  a_drain_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("request taken during drain");

  // an accepted flush stops the request side in the next cycle
  a_flush_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op |=> !in_ready)
    else $error("ready after flush request");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sorted_key_sum_aggregator skas_checker u_skas_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_op           (in_ch.op),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_entry_valid (out_ch.entry_valid),
  .out_last        (out_ch.last)
);
`default_nettype wire
